>>> rtl/cpu8_register_alu_execute_unit_assert.svh
// Assertion macros for the execute unit.
`ifndef CPU8_REGISTER_ALU_EXECUTE_UNIT_ASSERT_SVH
`define CPU8_REGISTER_ALU_EXECUTE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define CRE_ASSERT_IMPLY(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("cre assertion failed");

`define CRE_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("cre assertion failed");

`else

`define CRE_ASSERT_IMPLY(lbl, clk, rst, cond, expr)

`define CRE_ASSERT_NEXT(lbl, clk, rst, cond, expr)

`endif

`endif

>>> rtl/cre_pkg.sv
package cre_pkg;

   typedef logic [7:0] byte_type;
   typedef byte_type [7:0] regfile_type;
   typedef logic [4:0] flags_type;

   // flags_type bit positions
   localparam int unsigned FLAG_S  = 4;
   localparam int unsigned FLAG_Z  = 3;
   localparam int unsigned FLAG_AC = 2;
   localparam int unsigned FLAG_P  = 1;
   localparam int unsigned FLAG_C  = 0;

   localparam logic [2:0] REG_H = 3'd4;
   localparam logic [2:0] REG_L = 3'd5;
   localparam logic [2:0] REG_M = 3'd6;
   localparam logic [2:0] REG_A = 3'd7;

   localparam logic [2:0] ALU_ADD = 3'd0;
   localparam logic [2:0] ALU_ADC = 3'd1;
   localparam logic [2:0] ALU_SUB = 3'd2;
   localparam logic [2:0] ALU_SBB = 3'd3;
   localparam logic [2:0] ALU_ANA = 3'd4;
   localparam logic [2:0] ALU_XRA = 3'd5;
   localparam logic [2:0] ALU_ORA = 3'd6;
   localparam logic [2:0] ALU_CMP = 3'd7;

   localparam logic [1:0] GRP_MISC = 2'b00;
   localparam logic [1:0] GRP_MOV  = 2'b01;
   localparam logic [1:0] GRP_ALU  = 2'b10;

   localparam logic [2:0] LOW_INR = 3'd4;
   localparam logic [2:0] LOW_DCR = 3'd5;
   localparam logic [2:0] LOW_MVI = 3'd6;

   localparam byte_type OP_DAA = 8'h27;
   localparam byte_type OP_CMA = 8'h2F;
   localparam byte_type OP_STC = 8'h37;
   localparam byte_type OP_CMC = 8'h3F;
   localparam byte_type OP_HLT = 8'h76;

   typedef struct packed {
      regfile_type regs;
      flags_type   flags;
      logic        mem_write;
      byte_type    mem_data;
      logic        bad;
   } exec_type;

   function automatic flags_type szp_flags(input byte_type v, input logic ac,
                                           input logic cy);
      flags_type f;
      f          = '0;
      f[FLAG_S]  = v[7];
      f[FLAG_Z]  = (v == 8'h00);
      f[FLAG_AC] = ac;
      f[FLAG_P]  = ~^v;
      f[FLAG_C]  = cy;
      return f;
   endfunction

   // S Z 0 AC 0 P 1 C
   function automatic byte_type flag_byte(input flags_type f);
      return {f[FLAG_S], f[FLAG_Z], 1'b0, f[FLAG_AC], 1'b0, f[FLAG_P], 1'b1, f[FLAG_C]};
   endfunction

endpackage

>>> rtl/cre_exec.sv
module cre_exec (
   input  cre_pkg::byte_type    opcode,
   input  cre_pkg::byte_type    immediate,
   input  cre_pkg::byte_type    hl_byte,
   input  cre_pkg::regfile_type regs,
   input  cre_pkg::flags_type   flags,
   output cre_pkg::exec_type    result
);
   import cre_pkg::*;

   logic [2:0] dst;
   logic [2:0] src;
   logic       cy;
   byte_type   acc;
   byte_type   dst_val;
   byte_type   src_val;
   byte_type   add_b;
   logic       add_cin;
   logic [8:0] add_sum;
   logic [4:0] add_lo;
   byte_type   inc_val;
   byte_type   dec_val;
   logic       daa_lo_fix;
   logic       daa_hi_fix;
   byte_type   daa_corr;
   byte_type   daa_val;
   logic [4:0] daa_lo;
   byte_type   logic_val;

   assign dst     = opcode[5:3];
   assign src     = opcode[2:0];
   assign cy      = flags[FLAG_C];
   assign acc     = regs[REG_A];
   assign dst_val = (dst == REG_M) ? hl_byte : regs[dst];
   assign src_val = (src == REG_M) ? hl_byte : regs[src];
   assign inc_val = dst_val + 8'd1;
   assign dec_val = dst_val - 8'd1;

   // shared adder: subtract is A + ~B + !borrow
   always_comb begin
      case (dst)
         ALU_ADD: begin
            add_b   = src_val;
            add_cin = 1'b0;
         end
         ALU_ADC: begin
            add_b   = src_val;
            add_cin = cy;
         end
         ALU_SUB: begin
            add_b   = ~src_val;
            add_cin = 1'b1;
         end
         ALU_SBB: begin
            add_b   = ~src_val;
            add_cin = ~cy;
         end
         default: begin
            add_b   = src_val;
            add_cin = 1'b0;
         end
      endcase
   end

   assign add_sum = {1'b0, acc} + {1'b0, add_b} + {8'd0, add_cin};
   assign add_lo  = {1'b0, acc[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};

   assign daa_lo_fix = flags[FLAG_AC] || (acc[3:0] > 4'd9);
   assign daa_hi_fix = cy || (acc[7:4] > 4'd9) || ((acc[7:4] >= 4'd9) && (acc[3:0] > 4'd9));
   assign daa_corr   = {(daa_hi_fix ? 4'h6 : 4'h0), (daa_lo_fix ? 4'h6 : 4'h0)};
   assign daa_val    = acc + daa_corr;
   assign daa_lo     = {1'b0, acc[3:0]} + {1'b0, daa_corr[3:0]};

   always_comb begin
      case (dst)
         ALU_ANA: logic_val = acc & src_val;
         ALU_XRA: logic_val = acc ^ src_val;
         default: logic_val = acc | src_val;
      endcase
   end

   always_comb begin
      result.regs      = regs;
      result.flags     = flags;
      result.mem_write = 1'b0;
      result.mem_data  = 8'h00;
      result.bad       = 1'b0;
      if ((opcode[7:6] == GRP_MISC) && ((src == LOW_INR) || (src == LOW_DCR))) begin
         if (src == LOW_INR) begin
            result.flags = szp_flags(inc_val, inc_val[3:0] == 4'h0, cy);
            if (dst == REG_M) begin
               result.mem_write = 1'b1;
               result.mem_data  = inc_val;
            end else begin
               result.regs[dst] = inc_val;
            end
         end else begin
            result.flags = szp_flags(dec_val, dec_val[3:0] != 4'hF, cy);
            if (dst == REG_M) begin
               result.mem_write = 1'b1;
               result.mem_data  = dec_val;
            end else begin
               result.regs[dst] = dec_val;
            end
         end
      end else if ((opcode[7:6] == GRP_MISC) && (src == LOW_MVI)) begin
         if (dst == REG_M) begin
            result.mem_write = 1'b1;
            result.mem_data  = immediate;
         end else begin
            result.regs[dst] = immediate;
         end
      end else if (opcode == OP_CMA) begin
         result.regs[REG_A] = ~acc;
      end else if (opcode == OP_CMC) begin
         result.flags[FLAG_C] = ~cy;
      end else if (opcode == OP_STC) begin
         result.flags[FLAG_C] = 1'b1;
      end else if (opcode == OP_DAA) begin
         result.regs[REG_A] = daa_val;
         result.flags       = szp_flags(daa_val, daa_lo[4], cy | daa_hi_fix);
      end else if (opcode[7:6] == GRP_MOV) begin
         if (opcode == OP_HLT) begin
            result.bad = 1'b1;
         end else if (dst == REG_M) begin
            result.mem_write = 1'b1;
            result.mem_data  = regs[src];
         end else begin
            result.regs[dst] = src_val;
         end
      end else if (opcode[7:6] == GRP_ALU) begin
         case (dst)
            ALU_ADD, ALU_ADC: begin
               result.regs[REG_A] = add_sum[7:0];
               result.flags       = szp_flags(add_sum[7:0], add_lo[4], add_sum[8]);
            end
            ALU_SUB, ALU_SBB: begin
               // carry out inverted gives the borrow
               result.regs[REG_A] = add_sum[7:0];
               result.flags       = szp_flags(add_sum[7:0], add_lo[4], ~add_sum[8]);
            end
            ALU_ANA: begin
               result.regs[REG_A] = logic_val;
               result.flags       = szp_flags(logic_val, acc[3] | src_val[3], 1'b0);
            end
            ALU_XRA, ALU_ORA: begin
               result.regs[REG_A] = logic_val;
               result.flags       = szp_flags(logic_val, 1'b0, 1'b0);
            end
            default: begin
               // compare is not executed
               result.bad = 1'b1;
            end
         endcase
      end else begin
         result.bad = 1'b1;
      end
   end

endmodule

>>> rtl/cpu8_register_alu_execute_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  opcode, immediate, hl_byte
// rsp_      out        rsp_valid / rsp_ready  acc_value, flag_bits, mem_write,
//                                             mem_address, mem_data, unsupported
//
// One transaction per cycle sustained while rsp_ready is high; rsp_valid rises
// after the input register, once execute has loaded the result register.
// Registers and flags are written in the same cycle the result is loaded, so
// the next transaction in the input register sees them at once.
// Synchronous reset clears the register file, flags and all valid bits.
// A stalled rsp_ready holds the result and, once the input register is full,
// drops req_ready.
module cpu8_register_alu_execute_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cre_pkg::byte_type req_opcode,
   input  cre_pkg::byte_type req_immediate,
   input  cre_pkg::byte_type req_hl_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cre_pkg::byte_type rsp_acc_value,
   output cre_pkg::byte_type rsp_flag_bits,
   output logic              rsp_mem_write,
   output logic [15:0]       rsp_mem_address,
   output cre_pkg::byte_type rsp_mem_data,
   output logic              rsp_unsupported
);
   import cre_pkg::*;

   `include "cpu8_register_alu_execute_unit_assert.svh"

   logic        in_valid_ff;
   byte_type    in_opcode_ff;
   byte_type    in_immediate_ff;
   byte_type    in_hl_byte_ff;
   regfile_type regs_ff;
   flags_type   flags_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   byte_type    out_acc_ff;
   byte_type    out_flags_ff;
   logic        out_mem_write_ff;
   logic [15:0] out_address_ff;
   byte_type    out_mem_data_ff;
   logic        out_bad_ff;
   logic        fire;
   exec_type    exec;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   cre_exec u_exec (
      .opcode    (in_opcode_ff),
      .immediate (in_immediate_ff),
      .hl_byte   (in_hl_byte_ff),
      .regs      (regs_ff),
      .flags     (flags_ff),
      .result    (exec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_opcode_ff    <= req_opcode;
         in_immediate_ff <= req_immediate;
         in_hl_byte_ff   <= req_hl_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff  <= '0;
         flags_ff <= '0;
      end else if (fire) begin
         regs_ff  <= exec.regs;
         flags_ff <= exec.flags;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (fire) begin
         out_acc_ff       <= exec.regs[REG_A];
         out_flags_ff     <= flag_byte(exec.flags);
         out_mem_write_ff <= exec.mem_write;
         out_address_ff   <= {exec.regs[REG_H], exec.regs[REG_L]};
         out_mem_data_ff  <= exec.mem_data;
         out_bad_ff       <= exec.bad;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_acc_value   = out_acc_ff;
   assign rsp_flag_bits   = out_flags_ff;
   assign rsp_mem_write   = out_mem_write_ff;
   assign rsp_mem_address = out_address_ff;
   assign rsp_mem_data    = out_mem_data_ff;
   assign rsp_unsupported = out_bad_ff;

   `CRE_ASSERT_IMPLY(a_no_write_when_bad, clock, reset, rsp_valid, !(rsp_mem_write && rsp_unsupported))
   `CRE_ASSERT_IMPLY(a_data_zero_no_write, clock, reset, rsp_valid && !rsp_mem_write, rsp_mem_data == 8'h00)
   `CRE_ASSERT_IMPLY(a_flag_fixed_bits, clock, reset, rsp_valid, rsp_flag_bits[1] && !rsp_flag_bits[3] && !rsp_flag_bits[5])
   `CRE_ASSERT_NEXT(a_bad_keeps_state, clock, reset, fire && exec.bad, $stable(regs_ff) && $stable(flags_ff))

endmodule
